### rtl/qph_pkg.sv
// Shared types, codes and constants for the quadratic probe hash table.
package qph_pkg;

   localparam int TABLE_SIZE_DEF = 11;
   localparam int KEY_W = 31;
   localparam int NIBBLES = 8;
   localparam int HASH_BITS = NIBBLES * 4;
   localparam int SLOT_OUT_W = 4;
   localparam int OCC_OUT_W = 4;

   typedef enum logic [1:0] {
      ACT_SEARCH = 2'd0,
      ACT_INSERT = 2'd1,
      ACT_CLEAR  = 2'd2,
      ACT_NOP    = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_NOT_FOUND = 3'd0,
      ST_FOUND     = 3'd1,
      ST_INSERTED  = 3'd2,
      ST_FULL      = 3'd3,
      ST_CLEARED   = 3'd4
   } status_type;

   typedef struct packed {
      action_type       action;
      logic [KEY_W-1:0] key;
   } qph_req_type;

   typedef struct packed {
      status_type            status;
      logic [SLOT_OUT_W-1:0] slot_index;
      logic [OCC_OUT_W-1:0]  occupancy;
   } qph_rsp_type;

   typedef struct packed {
      logic       load;
      logic       hash_step;
      logic       probe_init;
      logic       probe_next;
      logic       clear_init;
      logic       sweep_step;
      logic       ins_write;
      logic       rsp_load;
      status_type rsp_status;
      logic       rsp_use_slot;
   } qph_cmd_type;

   typedef struct packed {
      logic hash_last;
      logic empty;
      logic match;
      logic last_probe;
      logic sweep_last;
      logic rsp_free;
   } qph_sts_type;

endpackage

### rtl/quadratic_probe_hash_table_core.sv
// Top level of the quadratic probe hash table: controller plus datapath.
//
//   channel   direction   handshake              payload
//   req       in          req_valid / req_stall  req_data (action, key)
//   rsp       out         rsp_valid / rsp_stall  rsp_data (status, slot_index, occupancy)
//
// Search or insert: the key is hashed a nibble at a time, then the slot memory
// gives one probe per cycle, taking 1 to TABLE_SIZE probes. Clear: one slot
// written per cycle. After reset a clearing pass runs with req_stall high. One
// transaction is in flight at a time; the result register lets the next
// transaction be accepted while a result waits under rsp_stall.
module quadratic_probe_hash_table_core
   import qph_pkg::*;
#(
   parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  qph_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output qph_rsp_type rsp_data
);

   qph_cmd_type cmd;
   qph_sts_type sts;

   qph_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_data.action),
      .sts        (sts),
      .req_stall  (req_stall),
      .cmd        (cmd)
   );

   qph_datapath #(
      .TABLE_SIZE (TABLE_SIZE)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

### rtl/qph_datapath.sv
// Datapath: key hashing, probe address generation, slot memory and result register.
module qph_datapath
   import qph_pkg::*;
#(
   parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  qph_req_type req_data,
   input  logic        rsp_stall,
   input  qph_cmd_type cmd,
   output qph_sts_type sts,
   output logic        rsp_valid,
   output qph_rsp_type rsp_data
);

   localparam int ADDR_W = $clog2(TABLE_SIZE);
   localparam int VAL_W = $clog2(TABLE_SIZE + 1);
   localparam int HW = VAL_W + 4;
   localparam int SW = VAL_W + 2;
   localparam logic [VAL_W-1:0] NV = VAL_W'(TABLE_SIZE);
   localparam logic [SW-1:0] N1S = SW'(TABLE_SIZE);
   localparam logic [SW-1:0] N2S = SW'(2 * TABLE_SIZE);

   logic [KEY_W:0] mem [TABLE_SIZE];
   logic [KEY_W:0] rd_ff;

   logic [KEY_W-1:0]     key_ff;
   logic [HASH_BITS-1:0] shift_ff, shift_in;
   logic [2:0]           hcnt_ff, hcnt_in;
   logic [VAL_W-1:0]     rem_ff, rem_in;
   logic [VAL_W-1:0]     j_ff, j_in;
   logic [VAL_W-1:0]     s_ff, s_in;
   logic [VAL_W-1:0]     sq_ff, sq_in;
   logic [VAL_W-1:0]     addr_ff, addr_in;
   logic [VAL_W-1:0]     count_ff, count_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   qph_rsp_type          rsp_ff, rsp_in;

   logic [HW-1:0]    hval;
   logic [VAL_W-1:0] j_nxt;
   logic [VAL_W-1:0] s_nxt;
   logic [SW-1:0]    sq_sum;
   logic [VAL_W-1:0] sq_nxt;
   logic [VAL_W:0]   add_sum;
   logic [VAL_W-1:0] addr_nxt;
   logic             mem_we;
   logic [KEY_W:0]   mem_wdata;

   always_comb begin
      hval = {rem_ff, shift_ff[HASH_BITS-1 -: 4]};
      for (int i = 3; i >= 0; i--) begin
         if (hval >= (HW'(TABLE_SIZE) << i)) begin
            hval = hval - (HW'(TABLE_SIZE) << i);
         end
      end
   end

   always_comb begin
      j_nxt = j_ff + VAL_W'(1);
      s_nxt = s_ff;
      sq_nxt = sq_ff;
      sq_sum = SW'(sq_ff) + {1'b0, s_ff, 1'b1};
      if (j_nxt[0]) begin
         s_nxt = (s_ff == NV - VAL_W'(1)) ? '0 : s_ff + VAL_W'(1);
         if (sq_sum >= N2S) begin
            sq_nxt = VAL_W'(sq_sum - N2S);
         end else if (sq_sum >= N1S) begin
            sq_nxt = VAL_W'(sq_sum - N1S);
         end else begin
            sq_nxt = VAL_W'(sq_sum);
         end
      end
      add_sum = {1'b0, rem_ff} + {1'b0, sq_nxt};
      if (j_nxt[0]) begin
         addr_nxt = (add_sum >= {1'b0, NV}) ? VAL_W'(add_sum - {1'b0, NV}) : VAL_W'(add_sum);
      end else if (rem_ff >= sq_nxt) begin
         addr_nxt = rem_ff - sq_nxt;
      end else begin
         addr_nxt = rem_ff + NV - sq_nxt;
      end
   end

   always_comb begin
      shift_in = shift_ff;
      hcnt_in = hcnt_ff;
      rem_in = rem_ff;
      j_in = j_ff;
      s_in = s_ff;
      sq_in = sq_ff;
      addr_in = addr_ff;
      count_in = count_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.load) begin
         shift_in = HASH_BITS'(req_data.key);
         hcnt_in = '0;
         rem_in = '0;
      end
      if (cmd.hash_step) begin
         shift_in = shift_ff << 4;
         hcnt_in = hcnt_ff + 3'd1;
         rem_in = VAL_W'(hval);
      end
      if (cmd.probe_init) begin
         j_in = '0;
         s_in = '0;
         sq_in = '0;
         addr_in = rem_ff;
      end
      if (cmd.probe_next) begin
         j_in = j_nxt;
         s_in = s_nxt;
         sq_in = sq_nxt;
         addr_in = addr_nxt;
      end
      if (cmd.clear_init) begin
         addr_in = '0;
         count_in = '0;
      end
      if (cmd.sweep_step) begin
         addr_in = addr_ff + VAL_W'(1);
      end
      if (cmd.ins_write) begin
         count_in = count_ff + VAL_W'(1);
      end
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_in.status = cmd.rsp_status;
         rsp_in.slot_index = cmd.rsp_use_slot ? SLOT_OUT_W'(addr_ff) : '0;
         rsp_in.occupancy = OCC_OUT_W'(count_ff);
      end
   end

   assign mem_we = cmd.sweep_step || cmd.ins_write;
   assign mem_wdata = {cmd.ins_write, key_ff};

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[addr_ff[ADDR_W-1:0]] <= mem_wdata;
      end
      rd_ff <= mem[addr_in[ADDR_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff <= '0;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         addr_ff <= addr_in;
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (cmd.load) begin
         key_ff <= req_data.key;
      end
      shift_ff <= shift_in;
      hcnt_ff <= hcnt_in;
      rem_ff <= rem_in;
      j_ff <= j_in;
      s_ff <= s_in;
      sq_ff <= sq_in;
      rsp_ff <= rsp_in;
   end

   assign sts.hash_last = (hcnt_ff == 3'(NIBBLES - 1));
   assign sts.empty = !rd_ff[KEY_W];
   assign sts.match = (rd_ff[KEY_W-1:0] == key_ff);
   assign sts.last_probe = (j_ff == NV - VAL_W'(1));
   assign sts.sweep_last = (addr_ff == NV - VAL_W'(1));
   assign sts.rsp_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

endmodule

### rtl/qph_ctrl.sv
// Controller: sequences hashing, probing, clearing and result delivery.
module qph_ctrl
   import qph_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  action_type  req_action,
   input  qph_sts_type sts,
   output logic        req_stall,
   output qph_cmd_type cmd
);

   typedef enum logic [2:0] {
      S_SWEEP,
      S_IDLE,
      S_HASH,
      S_PINIT,
      S_PROBE,
      S_RESP
   } state_type;

   state_type  state_ff, state_in;
   action_type op_ff, op_in;
   status_type res_ff, res_in;

   always_comb begin
      state_in = state_ff;
      op_in = op_ff;
      res_in = res_ff;
      cmd = '0;
      cmd.rsp_status = res_ff;
      cmd.rsp_use_slot = (res_ff == ST_FOUND) || (res_ff == ST_INSERTED);
      case (state_ff)
         S_SWEEP: begin
            cmd.sweep_step = 1'b1;
            if (sts.sweep_last) begin
               if (op_ff == ACT_CLEAR) begin
                  res_in = ST_CLEARED;
                  state_in = S_RESP;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               op_in = req_action;
               case (req_action)
                  ACT_SEARCH, ACT_INSERT: begin
                     state_in = S_HASH;
                  end
                  ACT_CLEAR: begin
                     cmd.clear_init = 1'b1;
                     state_in = S_SWEEP;
                  end
                  default: begin
                     res_in = ST_NOT_FOUND;
                     state_in = S_RESP;
                  end
               endcase
            end
         end
         S_HASH: begin
            cmd.hash_step = 1'b1;
            if (sts.hash_last) begin
               state_in = S_PINIT;
            end
         end
         S_PINIT: begin
            cmd.probe_init = 1'b1;
            state_in = S_PROBE;
         end
         S_PROBE: begin
            if (op_ff == ACT_INSERT) begin
               if (sts.empty) begin
                  cmd.ins_write = 1'b1;
                  res_in = ST_INSERTED;
                  state_in = S_RESP;
               end else if (sts.last_probe) begin
                  res_in = ST_FULL;
                  state_in = S_RESP;
               end else begin
                  cmd.probe_next = 1'b1;
               end
            end else begin
               if (sts.empty) begin
                  res_in = ST_NOT_FOUND;
                  state_in = S_RESP;
               end else if (sts.match) begin
                  res_in = ST_FOUND;
                  state_in = S_RESP;
               end else if (sts.last_probe) begin
                  res_in = ST_NOT_FOUND;
                  state_in = S_RESP;
               end else begin
                  cmd.probe_next = 1'b1;
               end
            end
         end
         S_RESP: begin
            if (sts.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_SWEEP;
         op_ff <= ACT_NOP;
         res_ff <= ST_NOT_FOUND;
      end else begin
         state_ff <= state_in;
         op_ff <= op_in;
         res_ff <= res_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

endmodule

### rtl/qph_checker.sv
// Port-level checks for the quadratic probe hash table, bound to the top level.
module qph_checker
   import qph_pkg::*;
#(
   parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input qph_req_type req_data,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input qph_rsp_type rsp_data
);

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_data))
      else $error("request changed while stalled");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second transaction accepted without a busy cycle");

   a_clear_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_CLEARED |-> rsp_data.occupancy == '0)
      else $error("clear reported nonzero occupancy");

   a_no_slot_on_miss: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == ST_NOT_FOUND || rsp_data.status == ST_FULL
         || rsp_data.status == ST_CLEARED) |-> rsp_data.slot_index == '0)
      else $error("slot index set on a result without a slot");

endmodule

bind quadratic_probe_hash_table_core qph_checker #(
   .TABLE_SIZE (TABLE_SIZE)
) u_qph_checker (.*);
